// File: src/wtr_pkg.sv
// shared constants and types for the windowed throughput rate meter
`default_nettype none
package wtr_pkg;

  localparam int WINDOW_DEF = 180;
  localparam int COUNT_W    = 16;
  localparam int PPH_W      = 12;
  localparam int RATE_W     = 28;
  localparam int HELD_W     = 8;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 40;

  localparam logic [PPH_W-1:0] PPH_RESET = 12'd180;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: src/wtr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module wtr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 180
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/wtr_mul.sv
// shift-add multiplier, one multiplier bit per cycle from the msb down
`default_nettype none
module wtr_mul #(
  parameter int A_W = 24,
  parameter int B_W = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic      [A_W+B_W-1:0] product
);

  localparam int P_W  = A_W + B_W;
  localparam int CN_W = $clog2(B_W + 1);

  logic [A_W-1:0]  a_r;
  logic [B_W-1:0]  b_r;
  logic [CN_W-1:0] cnt;
  logic            busy;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CN_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - CN_W'(1);
        if (cnt == CN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulate: double and add the multiplicand when the bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= a;
      b_r     <= b;
      product <= '0;
    end else if (busy) begin
      b_r     <= {b_r[B_W-2:0], 1'b0};
      product <= {product[P_W-2:0], 1'b0} + (b_r[B_W-1] ? {{B_W{1'b0}}, a_r} : P_W'(0));
    end
  end

endmodule
`default_nettype wire

// File: src/wtr_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module wtr_div #(
  parameter int N_W = 36,
  parameter int D_W = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic      [N_W-1:0] quotient
);

  localparam int CN_W = $clog2(N_W + 1);

  logic [D_W-1:0]  d_r;
  logic [D_W-1:0]  rem;
  logic [D_W:0]    trial;
  logic            fits;
  logic [CN_W-1:0] cnt;
  logic            busy;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, quotient[N_W-1]};
    fits  = (trial >= {1'b0, d_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CN_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - CN_W'(1);
        if (cnt == CN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      d_r      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? D_W'(trial - {1'b0, d_r}) : trial[D_W-1:0];
      quotient <= {quotient[N_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: src/windowed_throughput_rate.sv
// top level: sliding window throughput meter with serial multiply and divide
// a running transaction reads the store, then passes through the bit-serial multiplier and divider
//   into the output register; an idle transaction goes straight to the output register
// one transaction at a time: no new input is taken until the last one has reached the output register
// a finished result waits in the output register while the next transaction is taken
// reset: synchronous, clears window sum, fill count, pointer, last rate and scale to 180;
//   the window store is not cleared, an entry's old value is used only after it was written
`default_nettype none
module windowed_throughput_rate #(
  parameter int WINDOW = wtr_pkg::WINDOW_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: periods_per_hour
  input  wire logic                          cfg_we,
  input  wire logic [wtr_pkg::PPH_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [wtr_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] unit_count
  input  wire logic                          s_tuser,   // [0] running
  // output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [wtr_pkg::M_TDATA_W-1:0] m_tdata    // [27:0] rate, [35:28] periods_held
);

  import wtr_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = COUNT_W + $clog2(WINDOW);
  localparam int PROD_W = SUM_W + PPH_W;

  state_t state, state_next;

  logic [PPH_W-1:0]   pph;
  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   window_sum, window_sum_next;
  logic [CNT_W-1:0]   fill_count;
  logic [PTR_W-1:0]   write_pointer;
  logic [RATE_W-1:0]  last_rate;
  logic [RATE_W-1:0]  rate_out;
  logic [HELD_W-1:0]  held_out;

  logic               accept;
  logic               full;
  logic               ram_re, ram_we;
  logic [COUNT_W-1:0] ram_rdata;
  logic               mul_start, mul_done;
  logic [PROD_W-1:0]  product;
  logic               div_start, div_done;
  logic [PROD_W-1:0]  quotient;
  logic               load_out;
  logic               rate_we;

  assign accept = s_tvalid && s_tready;
  assign full   = (fill_count >= CNT_W'(WINDOW));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = s_tuser ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    rate_we   = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid && s_tuser;
      end
      ST_READ: begin
        ram_we    = 1'b1;
        mul_start = 1'b1;
      end
      ST_MUL:  div_start = mul_done;
      ST_DIV:  rate_we   = div_done;
      ST_DONE: load_out  = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // window sum after the new count enters and, once the window is full, the oldest leaves
  always_comb begin
    if (full) begin
      window_sum_next = window_sum - SUM_W'(ram_rdata) + SUM_W'(count);
    end else begin
      window_sum_next = window_sum + SUM_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      pph <= PPH_RESET;
    end else if (cfg_we) begin
      pph <= cfg_wdata;
    end
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
      last_rate     <= '0;
    end else begin
      if (state == ST_READ) begin
        window_sum <= window_sum_next;
        if (!full) begin
          fill_count <= fill_count + CNT_W'(1);
        end
        if (write_pointer == PTR_W'(WINDOW - 1)) begin
          write_pointer <= '0;
        end else begin
          write_pointer <= write_pointer + PTR_W'(1);
        end
      end
      if (rate_we) begin
        last_rate <= quotient[RATE_W-1:0];
      end
    end
  end

  // input count capture
  always_ff @(posedge clk) begin
    if (accept) begin
      count <= s_tdata[COUNT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rate_out <= last_rate;
      held_out <= HELD_W'(fill_count);
    end
  end

  assign m_tdata = {{(M_TDATA_W - RATE_W - HELD_W){1'b0}}, held_out, rate_out};

  // window store
  wtr_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (count),
    .re    (ram_re),
    .raddr (write_pointer),
    .rdata (ram_rdata)
  );

  // sum times scale
  wtr_mul #(
    .A_W (SUM_W),
    .B_W (PPH_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (window_sum_next),
    .b       (pph),
    .done    (mul_done),
    .product (product)
  );

  // divide by periods held
  wtr_div #(
    .N_W (PROD_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window depth");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside multiply state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_idle_item: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser) |=> (state == ST_DONE && $stable(fill_count) && $stable(last_rate)))
    else $error("idle transaction changed the window");

endmodule
`default_nettype wire

// File: tb/sv/wtr_rate_checker.sv
`timescale 1ns / 100ps
// checker for the windowed throughput rate meter: tracks the window, predicts rates, compares
module wtr_rate_checker #(
  parameter int WINDOW = wtr_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wtr_pkg::PPH_W-1:0]     cfg_wdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [wtr_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [wtr_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            mismatches,
  output int                            outstanding
);
  import wtr_pkg::*;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [HELD_W-1:0] held;
  } rate_report_t;

  // local copy of the meter state
  logic [COUNT_W-1:0] period_counts [WINDOW];
  logic [31:0]        units_in_window;
  int                 periods_in_window;
  int                 next_slot;
  logic [RATE_W-1:0]  held_rate;
  logic [PPH_W-1:0]   scale;

  rate_report_t pending_rates [$];
  rate_report_t want;
  rate_report_t got;

  initial mismatches = 0;

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // fold one closed period into the window and return the rate it reports
  function automatic rate_report_t fold_period(input logic run,
                                               input logic [COUNT_W-1:0] units);
    logic [47:0]  scaled;
    rate_report_t r;
    if (run) begin
      // full window: oldest count leaves before the new one takes its slot
      if (periods_in_window >= WINDOW) units_in_window -= period_counts[next_slot];
      else periods_in_window++;
      period_counts[next_slot] = units;
      units_in_window += units;
      next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
      scaled = 48'(units_in_window) * 48'(scale);
      held_rate = RATE_W'(scaled / 48'(periods_in_window));
    end
    r.rate = held_rate;
    r.held = HELD_W'(periods_in_window);
    return r;
  endfunction

  // watch both channels and the config port
  always @(posedge clk) begin
    if (rst) begin
      foreach (period_counts[i]) period_counts[i] = '0;
      units_in_window = '0;
      periods_in_window = 0;
      next_slot = 0;
      held_rate = '0;
      scale = PPH_RESET;
      pending_rates.delete();
    end else begin
      if (cfg_we) scale = cfg_wdata;
      // result transaction against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.rate = m_tdata[RATE_W-1:0];
        got.held = m_tdata[RATE_W +: HELD_W];
        if (pending_rates.size() == 0) begin
          report_mismatch($sformatf("unexpected result rate %0d periods %0d",
                                    got.rate, got.held));
        end else begin
          want = pending_rates.pop_front();
          if (got.rate !== want.rate)
            report_mismatch($sformatf("rate got %0d expected %0d", got.rate, want.rate));
          if (got.held !== want.held)
            report_mismatch($sformatf("periods_held got %0d expected %0d",
                                      got.held, want.held));
        end
      end
      // input transaction
      if (s_tvalid && s_tready) pending_rates.push_back(fold_period(s_tuser, s_tdata));
    end
    outstanding = pending_rates.size();
  end

endmodule

// File: tb/sv/windowed_throughput_rate_tb.sv
`timescale 1ns / 100ps
// testbench top for the windowed throughput rate meter: stimulus, back-pressure and verdict
module windowed_throughput_rate_tb;
  import wtr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [PPH_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tready  = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [M_TDATA_W-1:0]   m_tdata;

  int   mismatches;
  int   outstanding;
  int   feed_idle_pct   = 0;
  int   drain_stall_pct = 0;
  logic hold_go         = 1'b0;
  int   cycle_count     = 0;

  always #6 clk = ~clk;

  windowed_throughput_rate #(.WINDOW(WINDOW_DEF)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  wtr_rate_checker #(.WINDOW(WINDOW_DEF)) rate_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("windowed_throughput_rate_tb: FAIL");
      $finish;
    end
  end

  // result side readiness, with one long hold-off so the meter backs up
  initial begin : drain
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= drain_stall_pct);
    end
  end

  // offer one closed period, entered and left at a falling edge
  task automatic offer_period(input logic run, input logic [COUNT_W-1:0] units);
    while (feed_idle_pct != 0 && $urandom_range(99) < feed_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= run;
    s_tdata  <= units;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // scale write once every result is back
  task automatic write_scale(input logic [PPH_W-1:0] value);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // unit counts by flavor: uniform, extremes, tiny, near full scale
  function automatic logic [COUNT_W-1:0] pick_units(input int flavor);
    case (flavor)
      0: return COUNT_W'($urandom);
      1: return $urandom_range(1) ? '1 : '0;
      2: return COUNT_W'($urandom_range(15));
      default: return COUNT_W'($urandom_range(65535, 65000));
    endcase
  endfunction

  initial begin : stimulus
    int flavor;
    flavor = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: paused before any period, full scale, zero and unit scale
    offer_period(1'b0, 16'hFFFF);
    write_scale(12'd4095);
    offer_period(1'b1, 16'hFFFF);
    offer_period(1'b1, 16'h0000);
    offer_period(1'b0, 16'h5A5A);
    offer_period(1'b1, 16'h0001);
    offer_period(1'b1, 16'h8000);
    write_scale(12'd0);
    offer_period(1'b1, 16'hFFFF);
    offer_period(1'b0, 16'h0000);
    write_scale(12'd1);
    offer_period(1'b1, 16'h7FFF);
    offer_period(1'b1, 16'h0000);
    offer_period(1'b1, 16'hFFFF);
    write_scale(PPH_RESET);
    offer_period(1'b1, 16'h00FF);
    offer_period(1'b0, 16'hA5A5);
    offer_period(1'b1, 16'hFF00);

    // random phases, each setting a scale and an idling pattern
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin feed_idle_pct = 0;  drain_stall_pct = 0;  end
        1: begin feed_idle_pct = 68; drain_stall_pct = 0;  end
        2: begin feed_idle_pct = 0;  drain_stall_pct = 68; end
        default: begin feed_idle_pct = 23; drain_stall_pct = 23; end
      endcase
      case (phase)
        0: write_scale(PPH_RESET);
        1, 5: write_scale(12'd4095);
        3, 7: write_scale(12'd1);
        default: write_scale(PPH_W'($urandom_range(4095, 1)));
      endcase
      if (phase == 0) hold_go = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(29) == 0) flavor = $urandom_range(3);
        offer_period($urandom_range(99) < 85, pick_units(flavor));
      end
    end
    s_tvalid <= 1'b0;

    // drain and let the pipeline settle
    wait (outstanding == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("windowed_throughput_rate_tb: PASS");
    else $display("windowed_throughput_rate_tb: FAIL");
    $finish;
  end

endmodule
